[design/adcssm_pkg.sv]
// Package for the voltmeter display driver: command codes, scaling constants,
// digit types and the seven-segment glyph lookup. No dependencies.
package adcssm_pkg;

  typedef logic [3:0] digit_t;
  typedef logic [1:0] scan_pos_t;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_TICK   = 1'b1
  } cmd_t;

  // floor(sample * 196 / 100) == (sample * SCALE_MULT) >> SCALE_SHIFT for 8-bit samples
  localparam int unsigned SCALE_MULT_W = 18;
  localparam logic [SCALE_MULT_W-1:0] SCALE_MULT = 18'd256907;
  localparam int unsigned SCALE_SHIFT = 17;
  localparam int unsigned VOLT_W = 9;

  localparam logic [7:0] DP_BIT = 8'h80;

  localparam scan_pos_t POS_HUNDREDS = 2'd0;
  localparam scan_pos_t POS_TENS     = 2'd1;
  localparam scan_pos_t POS_UNITS    = 2'd2;

  // Segment pattern gfedcba for one decimal digit; blank for codes above nine.
  function automatic logic [7:0] glyph(input digit_t d);
    logic [7:0] seg;
    case (d)
      4'd0:    seg = 8'h3F;
      4'd1:    seg = 8'h06;
      4'd2:    seg = 8'h5B;
      4'd3:    seg = 8'h4F;
      4'd4:    seg = 8'h66;
      4'd5:    seg = 8'h6D;
      4'd6:    seg = 8'h7D;
      4'd7:    seg = 8'h07;
      4'd8:    seg = 8'h7F;
      4'd9:    seg = 8'h6F;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

endpackage

[design/adc_to_seven_segment_mux.sv]
// Top level of the voltmeter display driver: scales converter words to three
// decimal digits and scans them out as seven-segment words. Uses adcssm_pkg.
//
//  channel   | dir | tdata                                 | tuser | words
//  s_axis    | in  | [7:0] sample                          | cmd   | sample or scan tick
//  m_axis    | out | [7:0] segments, [10:8] digit_enable   | -     | one per tick
//
// Flow: a word is registered in the input register, the digit update or
//   glyph lookup happens on the way to the digit store / result register.
//   One word per cycle is sustained unless a tick waits on the result register.
// Reset: digits clear to zero, scan position to hundreds, both stages empty.
// Stalls: a sample word always drains; a tick word waits in the input
//   register while the result register is full and not taken, which holds
//   s_axis_tready low only when both stages are occupied.
module adc_to_seven_segment_mux (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] sample
  input  logic        s_axis_tuser,   // [0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [7:0] segments, [10:8] digit_enable, [15:11] zero
);

  // Input register
  logic       in_valid;
  logic       in_cmd;
  logic [7:0] in_sample;

  // State
  adcssm_pkg::digit_t    digits [3];
  adcssm_pkg::scan_pos_t scan_pos;

  // Result register
  logic       out_valid;
  logic [7:0] out_segments;
  logic [2:0] out_enable;

  logic out_free;
  logic in_move;

  // Scaling and digit split
  logic [adcssm_pkg::SCALE_MULT_W+7:0] scaled;
  logic [adcssm_pkg::VOLT_W-1:0]       volts;
  adcssm_pkg::digit_t                  hund;
  logic [adcssm_pkg::VOLT_W-1:0]       hund_sub;
  logic [6:0]                          rem;
  adcssm_pkg::digit_t                  tens;
  logic [6:0]                          tens_sub;
  adcssm_pkg::digit_t                  units;

  // Tick output
  logic [7:0]            seg_next;
  logic [2:0]            enable_next;
  adcssm_pkg::scan_pos_t scan_pos_next;

  assign out_free      = !out_valid || m_axis_tready;
  // Samples drain unconditionally; ticks need room in the result register.
  assign in_move       = in_valid && ((in_cmd == adcssm_pkg::CMD_SAMPLE) || out_free);
  assign s_axis_tready = !in_valid || in_move;

  always_comb begin
    scaled = {{adcssm_pkg::SCALE_MULT_W{1'b0}}, in_sample} *
             {8'd0, adcssm_pkg::SCALE_MULT};
    volts  = scaled[adcssm_pkg::SCALE_SHIFT +: adcssm_pkg::VOLT_W];

    if (volts >= 9'd400) begin
      hund = 4'd4; hund_sub = 9'd400;
    end else if (volts >= 9'd300) begin
      hund = 4'd3; hund_sub = 9'd300;
    end else if (volts >= 9'd200) begin
      hund = 4'd2; hund_sub = 9'd200;
    end else if (volts >= 9'd100) begin
      hund = 4'd1; hund_sub = 9'd100;
    end else begin
      hund = 4'd0; hund_sub = 9'd0;
    end
    rem = 7'(volts - hund_sub);

    if (rem >= 7'd90) begin
      tens = 4'd9; tens_sub = 7'd90;
    end else if (rem >= 7'd80) begin
      tens = 4'd8; tens_sub = 7'd80;
    end else if (rem >= 7'd70) begin
      tens = 4'd7; tens_sub = 7'd70;
    end else if (rem >= 7'd60) begin
      tens = 4'd6; tens_sub = 7'd60;
    end else if (rem >= 7'd50) begin
      tens = 4'd5; tens_sub = 7'd50;
    end else if (rem >= 7'd40) begin
      tens = 4'd4; tens_sub = 7'd40;
    end else if (rem >= 7'd30) begin
      tens = 4'd3; tens_sub = 7'd30;
    end else if (rem >= 7'd20) begin
      tens = 4'd2; tens_sub = 7'd20;
    end else if (rem >= 7'd10) begin
      tens = 4'd1; tens_sub = 7'd10;
    end else begin
      tens = 4'd0; tens_sub = 7'd0;
    end
    units = 4'(rem - tens_sub);
  end

  // Pick the digit at the scan position; a stray position three shows blank
  // and returns to hundreds.
  always_comb begin
    case (scan_pos)
      adcssm_pkg::POS_HUNDREDS: begin
        seg_next      = adcssm_pkg::glyph(digits[0]) | adcssm_pkg::DP_BIT;
        enable_next   = 3'b100;
        scan_pos_next = adcssm_pkg::POS_TENS;
      end
      adcssm_pkg::POS_TENS: begin
        seg_next      = adcssm_pkg::glyph(digits[1]);
        enable_next   = 3'b010;
        scan_pos_next = adcssm_pkg::POS_UNITS;
      end
      adcssm_pkg::POS_UNITS: begin
        seg_next      = adcssm_pkg::glyph(digits[2]);
        enable_next   = 3'b001;
        scan_pos_next = adcssm_pkg::POS_HUNDREDS;
      end
      default: begin
        seg_next      = 8'h00;
        enable_next   = 3'b000;
        scan_pos_next = adcssm_pkg::POS_HUNDREDS;
      end
    endcase
  end

  // Input register: load a word whenever the stage is empty or drains.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tready && s_axis_tvalid) begin
      in_cmd    <= s_axis_tuser;
      in_sample <= s_axis_tdata;
    end
  end

  // Digit store and scan position.
  always_ff @(posedge clk) begin
    if (rst) begin
      digits[0] <= '0;
      digits[1] <= '0;
      digits[2] <= '0;
      scan_pos  <= adcssm_pkg::POS_HUNDREDS;
    end else if (in_move) begin
      if (in_cmd == adcssm_pkg::CMD_SAMPLE) begin
        digits[0] <= hund;
        digits[1] <= tens;
        digits[2] <= units;
      end else begin
        scan_pos <= scan_pos_next;
      end
    end
  end

  // Result register: hold until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_move && (in_cmd == adcssm_pkg::CMD_TICK);
    end
    if (out_free && in_move && (in_cmd == adcssm_pkg::CMD_TICK)) begin
      out_segments <= seg_next;
      out_enable   <= enable_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'd0, out_enable, out_segments};

  // Scan position never reaches the unused code.
  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    scan_pos != 2'd3)
    else $error("scan position left the digit range");

  // Stored digits stay decimal.
  a_digits_decimal: assert property (@(posedge clk) disable iff (rst)
    digits[0] <= 4'd4 && digits[1] <= 4'd9 && digits[2] <= 4'd9)
    else $error("stored digit out of range");

  // Every emitted word drives exactly one digit.
  a_enable_onehot: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot(out_enable))
    else $error("digit enable not one-hot");

  // Decimal point appears only on the hundreds digit.
  a_dp_hundreds: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_segments[7] == out_enable[2]))
    else $error("decimal point on wrong digit");

  // A tick that drains advances the scan position.
  a_scan_advance: assert property (@(posedge clk) disable iff (rst)
    (in_move && in_cmd == adcssm_pkg::CMD_TICK) |=> (scan_pos != $past(scan_pos)))
    else $error("scan position did not advance on tick");

endmodule
